// ===== src/matrix_inverse_3x3_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 matrix inverse.
// Each check is active in simulation and compiles to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef MATRIX_INVERSE_3X3_ASSERT_SVH
`define MATRIX_INVERSE_3X3_ASSERT_SVH
`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define MI3_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("mi3 check failed");
// The property must never hold at a clock edge outside reset.
`define MI3_ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
    else $error("mi3 check failed");
`else
`define MI3_ASSERT(lbl, clk, rstn, prop)
`define MI3_ASSERT_NEVER(lbl, clk, rstn, prop)
`endif
`endif

// ===== src/mi3_pkg.sv =====
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared types and constants of the 3x3 matrix inverse.
// ----------------------------------------------------------------------------
`default_nettype none

package mi3_pkg;

  // Element word width and the widths of the exact intermediate values.
  localparam int unsigned WORD_W = 32;
  localparam int unsigned COF_W  = 2 * WORD_W + 1;
  localparam int unsigned DET_W  = 3 * WORD_W + 3;
  localparam int unsigned N_ELEM = 9;

  typedef logic signed [WORD_W-1:0] word_t;

  // Operand indexes of each cofactor: c = e[a]*e[b] - e[c]*e[d].
  localparam int unsigned COF_IDX [N_ELEM][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  typedef struct packed {
    word_t in_r1c1;
    word_t in_r1c2;
    word_t in_r1c3;
    word_t in_r2c1;
    word_t in_r2c2;
    word_t in_r2c3;
    word_t in_r3c1;
    word_t in_r3c2;
    word_t in_r3c3;
  } mi3_in_t;

  typedef struct packed {
    word_t out_r1c1;
    word_t out_r1c2;
    word_t out_r1c3;
    word_t out_r2c1;
    word_t out_r2c2;
    word_t out_r2c3;
    word_t out_r3c1;
    word_t out_r3c2;
    word_t out_r3c3;
    word_t determinant;
    logic  invertible;
  } mi3_out_t;

  // One classified item as it passes from the front part to the back part.
  typedef struct packed {
    logic [N_ELEM-1:0][WORD_W-1:0] elem;
    logic [N_ELEM-1:0][COF_W-1:0]  cof;
    logic [DET_W-1:0]              det;
  } mi3_work_t;

endpackage

`default_nettype wire

// ===== src/mi3_front.sv =====
// ----------------------------------------------------------------------------
// mi3_front
// Five-stage pipeline that forms the nine exact cofactors and the exact
// determinant of each accepted matrix and pushes them into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mi3_front import mi3_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  mi3_in_t   in_data_i,
  output logic      push_o,
  output mi3_work_t work_o,
  input  logic      q_full_i
);

  localparam int unsigned W    = WORD_W;
  localparam int unsigned PP_W = 2 * W + 1;
  localparam int unsigned NS   = 5;

  logic [NS-1:0] vld_q;
  logic          en;

  logic signed [W-1:0]     in_e  [N_ELEM];
  logic signed [W-1:0]     e1_q  [N_ELEM];
  logic signed [2*W-1:0]   pa_q  [N_ELEM];
  logic signed [2*W-1:0]   pb_q  [N_ELEM];
  logic signed [W-1:0]     e2_q  [N_ELEM];
  logic signed [COF_W-1:0] c2_q  [N_ELEM];
  logic signed [W-1:0]     e3_q  [N_ELEM];
  logic signed [COF_W-1:0] c3_q  [N_ELEM];
  logic signed [PP_W-1:0]  plo_q [3];
  logic signed [PP_W-1:0]  phi_q [3];
  logic signed [W-1:0]     e4_q  [N_ELEM];
  logic signed [COF_W-1:0] c4_q  [N_ELEM];
  logic signed [DET_W-1:0] t_q   [3];
  mi3_work_t               work_q;

  // Unpack the input item into row-major elements.
  assign in_e[0] = in_data_i.in_r1c1;
  assign in_e[1] = in_data_i.in_r1c2;
  assign in_e[2] = in_data_i.in_r1c3;
  assign in_e[3] = in_data_i.in_r2c1;
  assign in_e[4] = in_data_i.in_r2c2;
  assign in_e[5] = in_data_i.in_r2c3;
  assign in_e[6] = in_data_i.in_r3c1;
  assign in_e[7] = in_data_i.in_r3c2;
  assign in_e[8] = in_data_i.in_r3c3;

  // The whole front advances unless its last stage waits on a full queue.
  assign en         = !(vld_q[NS-1] && q_full_i);
  assign in_ready_o = en;
  assign push_o     = vld_q[NS-1] && !q_full_i;
  assign work_o     = work_q;

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NS-2:0], in_valid_i};
    end
  end

  // Datapath stages: products, cofactors, split products, partial sums, sum.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < N_ELEM; k++) begin
        e1_q[k] <= in_e[k];
        pa_q[k] <= in_e[COF_IDX[k][0]] * in_e[COF_IDX[k][1]];
        pb_q[k] <= in_e[COF_IDX[k][2]] * in_e[COF_IDX[k][3]];
        e2_q[k] <= e1_q[k];
        c2_q[k] <= COF_W'(pa_q[k]) - COF_W'(pb_q[k]);
        e3_q[k] <= e2_q[k];
        c3_q[k] <= c2_q[k];
        e4_q[k] <= e3_q[k];
        c4_q[k] <= c3_q[k];
        work_q.elem[k] <= e4_q[k];
        work_q.cof[k]  <= c4_q[k];
      end
      for (int j = 0; j < 3; j++) begin
        plo_q[j] <= e2_q[j] * $signed({1'b0, c2_q[3*j][W-1:0]});
        phi_q[j] <= e2_q[j] * $signed(c2_q[3*j][COF_W-1:W]);
        t_q[j]   <= (DET_W'(phi_q[j]) <<< W) + DET_W'(plo_q[j]);
      end
      work_q.det <= t_q[0] + t_q[1] + t_q[2];
    end
  end

endmodule

`default_nettype wire

// ===== src/mi3_queue.sv =====
// ----------------------------------------------------------------------------
// mi3_queue
// Two-entry queue of classified items between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module mi3_queue import mi3_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  mi3_work_t push_data_i,
  output logic      full_o,
  input  logic      pop_i,
  output mi3_work_t pop_data_o,
  output logic      empty_o
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  mi3_work_t        mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [PTR_W:0]   cnt_q;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == (PTR_W+1)'(DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/mi3_back.sv =====
// ----------------------------------------------------------------------------
// mi3_back
// Pipelined restoring divider, one quotient bit per stage for all nine
// lanes, with sign handling, saturation and the singular pass-through.
// ----------------------------------------------------------------------------
`default_nettype none

`include "matrix_inverse_3x3_assert.svh"

module mi3_back import mi3_pkg::*; #(
  parameter int unsigned FracBits = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  output logic      pop_o,
  input  mi3_work_t work_i,
  input  logic      q_empty_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output mi3_out_t  out_data_o
);

  localparam int unsigned W    = WORD_W;
  localparam int unsigned RW   = DET_W + W;
  localparam int unsigned LAST = W + 1;
  localparam int unsigned FS   = 2 * FracBits;

  localparam logic [W-1:0] MAX_W  = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MIN_W  = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] HALF_W = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic [N_ELEM-1:0][RW-1:0] rem;
    logic [N_ELEM-1:0][W-1:0]  quo;
    logic [N_ELEM-1:0]         ovf;
    logic [N_ELEM-1:0]         neg;
    logic [DET_W-1:0]          dmag;
    logic                      dneg;
    logic                      nz;
    logic [N_ELEM-1:0][W-1:0]  elem;
  } stage_t;

  stage_t        st_d [LAST+1];
  stage_t        st_q [LAST+1];
  logic [LAST:0] vld_q;
  logic          out_valid_q;
  mi3_out_t      out_d, out_q;
  logic          en;

  // The back stalls only while a finished item waits at the output.
  assign en          = !out_valid_q || out_ready_i;
  assign pop_o       = en && !q_empty_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Magnitudes and signs, overflow check, then one quotient bit per stage.
  always_comb begin
    logic signed [COF_W-1:0] cs;
    logic [COF_W-1:0]        ca;
    logic signed [DET_W-1:0] ds;
    logic [RW-1:0]           sub;
    ds = $signed(work_i.det);
    st_d[0]      = '0;
    st_d[0].dneg = ds[DET_W-1];
    st_d[0].dmag = ds[DET_W-1] ? DET_W'(-ds) : DET_W'(ds);
    st_d[0].nz   = |ds;
    for (int i = 0; i < N_ELEM; i++) begin
      cs = $signed(work_i.cof[i]);
      ca = cs[COF_W-1] ? COF_W'(-cs) : COF_W'(cs);
      st_d[0].rem[i]  = RW'(ca) << FS;
      st_d[0].neg[i]  = cs[COF_W-1] ^ ds[DET_W-1];
      st_d[0].elem[i] = work_i.elem[i];
    end
    // A quotient of 2^W or more saturates whatever its sign.
    st_d[1] = st_q[0];
    sub     = RW'(st_q[0].dmag) << W;
    for (int i = 0; i < N_ELEM; i++) begin
      st_d[1].ovf[i] = (st_q[0].rem[i] >= sub);
    end
    for (int s = 2; s <= LAST; s++) begin
      st_d[s] = st_q[s-1];
      sub     = RW'(st_q[s-1].dmag) << (LAST - s);
      for (int i = 0; i < N_ELEM; i++) begin
        if (st_q[s-1].rem[i] >= sub) begin
          st_d[s].rem[i]           = st_q[s-1].rem[i] - sub;
          st_d[s].quo[i][LAST - s] = 1'b1;
        end
      end
    end
  end

  // Apply signs, saturate, and select the pass-through for a singular matrix.
  always_comb begin
    logic [W-1:0]     r [N_ELEM];
    logic [W-1:0]     q;
    logic [DET_W-1:0] dsh;
    logic [W-1:0]     dout;
    for (int i = 0; i < N_ELEM; i++) begin
      q = st_q[LAST].quo[i];
      if (!st_q[LAST].nz) begin
        r[i] = st_q[LAST].elem[i];
      end else if (st_q[LAST].ovf[i]) begin
        r[i] = st_q[LAST].neg[i] ? MIN_W : MAX_W;
      end else if (st_q[LAST].neg[i]) begin
        r[i] = (q > HALF_W) ? MIN_W : W'(-q);
      end else begin
        r[i] = q[W-1] ? MAX_W : q;
      end
    end
    dsh = st_q[LAST].dmag >> FS;
    if (st_q[LAST].dneg) begin
      dout = (dsh > DET_W'(HALF_W)) ? MIN_W : W'(-dsh[W-1:0]);
    end else begin
      dout = (|dsh[DET_W-1:W-1]) ? MAX_W : dsh[W-1:0];
    end
    out_d.out_r1c1    = r[0];
    out_d.out_r1c2    = r[1];
    out_d.out_r1c3    = r[2];
    out_d.out_r2c1    = r[3];
    out_d.out_r2c2    = r[4];
    out_d.out_r2c3    = r[5];
    out_d.out_r3c1    = r[6];
    out_d.out_r3c2    = r[7];
    out_d.out_r3c3    = r[8];
    out_d.determinant = st_q[LAST].nz ? dout : '0;
    out_d.invertible  = st_q[LAST].nz;
  end

  // Stage valid bits and the output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[LAST-1:0], !q_empty_i};
      out_valid_q <= vld_q[LAST];
    end
  end

  // Stage payloads and the output register.
  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q  <= st_d;
      out_q <= out_d;
    end
  end

  `MI3_ASSERT(a_freeze_on_stall, clk_i, rst_ni, !en |=> $stable(vld_q) && out_valid_q)
  `MI3_ASSERT(a_last_to_output, clk_i, rst_ni, vld_q[LAST] && en |=> out_valid_q)
  `MI3_ASSERT_NEVER(a_singular_det, clk_i, rst_ni, out_valid_q && !out_q.invertible && out_q.determinant != '0)

endmodule

`default_nettype wire

// ===== src/matrix_inverse_3x3.sv =====
// ----------------------------------------------------------------------------
// matrix_inverse_3x3
// Inverse of a signed fixed-point 3x3 matrix by the adjugate, with the
// exact determinant, singular pass-through and saturation.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i/in_ready_o  | in_data_i  (mi3_in_t)
//   out     | output    | out_valid_o/out_ready_i| out_data_o (mi3_out_t)
//
// One item per cycle sustained while the output is not stalled. The divider
// resolves one quotient bit per stage for all nine elements. Reset clears
// only the valid bits and the queue pointers and fill count. A stalled
// output freezes the divider; the front keeps accepting until the two-entry
// queue is full and an item waits in the last of its five stages.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_inverse_3x3 import mi3_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  mi3_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output mi3_out_t out_data_o
);

  logic      push, q_full, pop, q_empty;
  mi3_work_t push_data, pop_data;

  // Cofactors and determinant.
  mi3_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .work_o     (push_data),
    .q_full_i   (q_full)
  );

  // Decoupling queue.
  mi3_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (q_empty)
  );

  // Division and output formatting.
  mi3_back #(
    .FracBits (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_o       (pop),
    .work_i      (pop_data),
    .q_empty_i   (q_empty),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
